FILE: design/lprf_pkg.sv
// shared types, request and status codes for the length-prefixed record fifo
package lprf_pkg;

    // default ring size in words (a power of two)
    localparam int DEPTH_DEF = 1024;

    // request kinds
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_DATA  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_ORDER    = 3'd2;
    localparam logic [2:0] ST_ZERO     = 3'd3;
    localparam logic [2:0] ST_LONG     = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;
    localparam logic [2:0] ST_SEQ      = 3'd6;

    // one request item
    typedef struct packed {
        logic [1:0]         req_type;
        logic [15:0]        rec_len;
        logic [31:0]        serial;
        logic signed [31:0] data_in;
    } req_t;

    // one response item
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] data_out;
        logic               last_word;
        logic [31:0]        record_count;
    } rsp_t;

    // ring access from the sequencer, positions are stream word numbers
    typedef struct packed {
        logic        wr_en;
        logic [31:0] wr_pos;
        logic [31:0] wr_word;
        logic        rd_en;
        logic [31:0] rd_pos;
    } mem_req_t;

endpackage

FILE: design/lprf_ring.sv
// ring word memory: one write and one registered read per cycle
module lprf_ring
    import lprf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  mem_req_t    mreq,
    output logic [31:0] rd_word
);

    localparam int AW = $clog2(DEPTH);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_word_reg;

    // stream position maps to slot by its low bits
    always_ff @(posedge clk)
    begin
        if (mreq.wr_en)
        begin
            mem[mreq.wr_pos[AW-1:0]] <= mreq.wr_word;
        end
        if (mreq.rd_en)
        begin
            rd_word_reg <= mem[mreq.rd_pos[AW-1:0]];
        end
    end

    assign rd_word = rd_word_reg;

endmodule

FILE: design/lprf_ctrl.sv
// request sequencer: record checks, counters and ring read/modify/write
module lprf_ctrl
    import lprf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  req_t        req,
    input  logic [31:0] rd_word,
    output mem_req_t    mreq,
    output logic        idle,
    output logic        res_valid,
    output rsp_t        res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LEN  = 3'b010,
        S_DATA = 3'b100
    } state_t;

    localparam logic [32:0] DEPTH_U = 33'(DEPTH);

    state_t      state_reg, state_next;
    logic [31:0] words_in_reg, words_in_next;
    logic [31:0] words_out_reg, words_out_next;
    logic [31:0] records_in_reg, records_in_next;
    logic [31:0] records_out_reg, records_out_next;
    logic [15:0] write_left_reg, write_left_next;
    logic [15:0] read_left_reg, read_left_next;
    logic [15:0] open_write_len_reg, open_write_len_next;
    logic [15:0] open_read_len_reg, open_read_len_next;
    logic [31:0] wr_ptr_reg, wr_ptr_next;
    logic [31:0] rd_ptr_reg, rd_ptr_next;
    logic [31:0] used;
    logic [32:0] need;

    assign used = words_in_reg - words_out_reg;
    assign need = {1'b0, used} + {17'b0, req.rec_len} + 33'd1;
    assign idle = (state_reg == S_IDLE);

    // next state, ring access and response
    always_comb
    begin
        state_next          = state_reg;
        words_in_next       = words_in_reg;
        words_out_next      = words_out_reg;
        records_in_next     = records_in_reg;
        records_out_next    = records_out_reg;
        write_left_next     = write_left_reg;
        read_left_next      = read_left_reg;
        open_write_len_next = open_write_len_reg;
        open_read_len_next  = open_read_len_reg;
        wr_ptr_next         = wr_ptr_reg;
        rd_ptr_next         = rd_ptr_reg;
        mreq                = '0;
        res_valid           = 1'b0;
        res                 = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req.req_type)
                        REQ_START:
                        begin
                            res_valid        = 1'b1;
                            res.record_count = records_in_reg;
                            if (write_left_reg != 16'd0)
                            begin
                                res.status = ST_SEQ;
                            end
                            else if (req.rec_len == 16'd0)
                            begin
                                res.status = ST_ZERO;
                            end
                            else if ({17'b0, req.rec_len} > DEPTH_U)
                            begin
                                res.status = ST_LONG;
                            end
                            else if (req.serial != 32'd0 &&
                                     req.serial - 32'd1 != records_in_reg)
                            begin
                                res.status = ST_ORDER;
                            end
                            else if (!(need < DEPTH_U))
                            begin
                                res.status = ST_NO_SPACE;
                            end
                            else
                            begin
                                // store the length word, open the record
                                res.status          = ST_OK;
                                mreq.wr_en          = 1'b1;
                                mreq.wr_pos         = words_in_reg;
                                mreq.wr_word        = {16'b0, req.rec_len};
                                open_write_len_next = req.rec_len;
                                write_left_next     = req.rec_len;
                                wr_ptr_next         = words_in_reg + 32'd1;
                            end
                        end
                        REQ_DATA:
                        begin
                            res_valid        = 1'b1;
                            res.record_count = records_in_reg;
                            if (write_left_reg == 16'd0)
                            begin
                                res.status = ST_SEQ;
                            end
                            else
                            begin
                                res.status      = ST_OK;
                                mreq.wr_en      = 1'b1;
                                mreq.wr_pos     = wr_ptr_reg;
                                mreq.wr_word    = req.data_in;
                                wr_ptr_next     = wr_ptr_reg + 32'd1;
                                write_left_next = write_left_reg - 16'd1;
                                // commit on the last data word
                                if (write_left_reg == 16'd1)
                                begin
                                    words_in_next    = words_in_reg
                                                     + {16'b0, open_write_len_reg} + 32'd1;
                                    records_in_next  = records_in_reg + 32'd1;
                                    res.record_count = records_in_reg + 32'd1;
                                    res.last_word    = 1'b1;
                                end
                            end
                        end
                        REQ_READ:
                        begin
                            if (read_left_reg != 16'd0)
                            begin
                                mreq.rd_en  = 1'b1;
                                mreq.rd_pos = rd_ptr_reg;
                                state_next  = S_DATA;
                            end
                            else if (records_out_reg == records_in_reg)
                            begin
                                res_valid        = 1'b1;
                                res.status       = ST_EMPTY;
                                res.record_count = records_out_reg;
                            end
                            else
                            begin
                                // fetch the length word of the oldest record
                                mreq.rd_en  = 1'b1;
                                mreq.rd_pos = words_out_reg;
                                state_next  = S_LEN;
                            end
                        end
                        default:
                        begin
                            res_valid        = 1'b1;
                            res.status       = ST_SEQ;
                            res.record_count = records_out_reg;
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                open_read_len_next = rd_word[15:0];
                read_left_next     = rd_word[15:0];
                if (rd_word[15:0] == 16'd0)
                begin
                    res_valid        = 1'b1;
                    res.status       = ST_EMPTY;
                    res.record_count = records_out_reg;
                    state_next       = S_IDLE;
                end
                else
                begin
                    mreq.rd_en  = 1'b1;
                    mreq.rd_pos = words_out_reg + 32'd1;
                    rd_ptr_next = words_out_reg + 32'd1;
                    state_next  = S_DATA;
                end
            end
            S_DATA:
            begin
                res_valid        = 1'b1;
                res.status       = ST_OK;
                res.data_out     = rd_word;
                res.record_count = records_out_reg;
                rd_ptr_next      = rd_ptr_reg + 32'd1;
                read_left_next   = read_left_reg - 16'd1;
                state_next       = S_IDLE;
                // record finished on its last word
                if (read_left_reg == 16'd1)
                begin
                    words_out_next   = words_out_reg
                                     + {16'b0, open_read_len_reg} + 32'd1;
                    records_out_next = records_out_reg + 32'd1;
                    res.record_count = records_out_reg + 32'd1;
                    res.last_word    = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            words_in_reg       <= '0;
            words_out_reg      <= '0;
            records_in_reg     <= '0;
            records_out_reg    <= '0;
            write_left_reg     <= '0;
            read_left_reg      <= '0;
            open_write_len_reg <= '0;
            open_read_len_reg  <= '0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            words_in_reg       <= words_in_next;
            words_out_reg      <= words_out_next;
            records_in_reg     <= records_in_next;
            records_out_reg    <= records_out_next;
            write_left_reg     <= write_left_next;
            read_left_reg      <= read_left_next;
            open_write_len_reg <= open_write_len_next;
            open_read_len_reg  <= open_read_len_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
        end
    end

`ifndef SYNTHESIS
    // committed words never exceed the ring
    a_used_fits: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, used} < DEPTH_U)
        else $error("committed words exceed ring size");

    // no records pending means no words pending
    a_empty_match: assert property (@(posedge clk) disable iff (!rst_n)
        records_in_reg == records_out_reg |-> words_in_reg == words_out_reg)
        else $error("record and word counters disagree");

    // an open read belongs to a committed record
    a_read_open: assert property (@(posedge clk) disable iff (!rst_n)
        read_left_reg != 16'd0 |-> records_in_reg != records_out_reg)
        else $error("read open with nothing committed");

    // a ring read is always followed by a wait for its data
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.rd_en |=> (state_reg == S_LEN || state_reg == S_DATA))
        else $error("ring read issued without a wait state");

    // the open write never has more words due than its length
    a_write_left: assert property (@(posedge clk) disable iff (!rst_n)
        write_left_reg <= open_write_len_reg)
        else $error("write count above record length");
`endif

endmodule

FILE: design/length_prefixed_record_fifo.sv
// top level of the length-prefixed record fifo: handshake and response register
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------
//   request  | in        | req_valid / req_ready   | req_data  (lprf_pkg::req_t)
//   response | out       | rsp_valid / rsp_ready   | rsp_data  (lprf_pkg::rsp_t)
//
// start, data and reject requests are answered from the idle state; a read
// waits in S_DATA (after S_LEN when it opens a record), as the ring read port
// is registered: the length word must return before the first data word read.
// one request is in work at a time; a new request is taken in the cycle
// the response register empties or is being taken.
// reset clears all counters, so the fifo starts empty; the ring needs no
// clearing since only written words are ever read.
// DEPTH must be a power of two.
module length_prefixed_record_fifo
    import lprf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req_data,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp_data
);

    mem_req_t    mreq;
    logic [31:0] rd_word;
    logic        idle;
    logic        res_valid;
    rsp_t        res;
    logic        start;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_data_reg;

    // take a request when the sequencer is free and the response slot clears
    assign req_ready = idle && (!rsp_valid_reg || rsp_ready);
    assign start     = req_valid && req_ready;

    lprf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req_data),
        .rd_word   (rd_word),
        .mreq      (mreq),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res)
    );

    lprf_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .mreq    (mreq),
        .rd_word (rd_word)
    );

    // response slot valid
    always_comb
    begin
        if (res_valid)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            rsp_data_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef SYNTHESIS
    // a new response never lands on one still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!rsp_valid_reg || rsp_ready))
        else $error("response overwrites a pending response");

    // a held response stays until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("pending response dropped or changed");

    // no request is taken while the sequencer is busy
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> !req_ready)
        else $error("request taken while busy");
`endif

endmodule
